FILE: src/fpb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpb_pkg
// Shared constants for the free page bitmap: default size, word geometry,
// payload widths, request kinds and status codes.
// ----------------------------------------------------------------------------
package fpb_pkg;

   // default number of pages tracked by the map
   localparam int PAGES_DEF = 32768;

   // bitmap word geometry
   localparam int WORD_BITS = 64;
   localparam int BIT_AW    = 6;

   // payload widths
   localparam int PAGE_W      = 16;
   localparam int FREE_PAGE_W = 15;
   localparam int KIND_W      = 2;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_MARK_FREE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MARK_FULL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIND      = 2'd2;

   // response status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_PAGE = 1'b1;

endpackage
`default_nettype wire

FILE: src/free_page_bitmap.sv
`default_nettype none
// Sequence: a mark in range passes ST_MODIFY and ST_DONE; a find with a hit passes
// ST_WORD, ST_BIT and ST_DONE; a bad page, a find on an empty map and the unused kind
// go straight to ST_DONE, which loads the registered response word.
// Throughput: one request at a time, set by the read-modify-write pass through the
// bitmap memory and its registered read, held while the response waits on rsp_tready.
// Reset: synchronous, active high; clears the per-word nonzero summary, no memory pass.
// ----------------------------------------------------------------------------
// free_page_bitmap
// One bit per page in a word-wide memory. A per-word nonzero summary gates stale
// memory contents and drives a three-level lowest-free-page search.
// ----------------------------------------------------------------------------
module free_page_bitmap #(
   parameter int PAGES = fpb_pkg::PAGES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] page (signed)
   input  wire logic [1:0]  req_tuser,   // [1:0] kind
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [14:0] free_page, [15] zero
   output logic [1:0]       rsp_tuser    // [0] status, [1] found
);

   localparam int WB       = fpb_pkg::WORD_BITS;
   localparam int BAW      = fpb_pkg::BIT_AW;
   localparam int WORDS    = (PAGES + WB - 1) / WB;
   localparam int WORD_AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int GROUPS   = (WORDS + WB - 1) / WB;
   localparam int GROUP_AW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int SUM_BITS = GROUPS * WB;
   localparam int FPW      = fpb_pkg::FREE_PAGE_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MODIFY = 5'b00010,
      ST_WORD   = 5'b00100,
      ST_BIT    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [fpb_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [WORD_AW-1:0]         waddr_ff, waddr_in;
   logic [BAW-1:0]             bit_ff, bit_in;
   logic [GROUP_AW-1:0]        grp_ff, grp_in;
   logic                       res_status_ff, res_status_in;
   logic                       res_found_ff, res_found_in;
   logic [FPW-1:0]             res_page_ff, res_page_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_status_ff, rsp_status_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [FPW-1:0]             rsp_page_ff, rsp_page_in;
   logic [WORDS-1:0]           nz_ff, nz_in;

   // bitmap memory
   logic [WB-1:0]              mem [WORDS];
   logic [WB-1:0]              rd_ff;
   logic [WORD_AW-1:0]         raddr;
   logic                       wr_en;
   logic [WB-1:0]              wr_word;

   logic                       req_acc;
   logic                       in_range;
   logic [SUM_BITS-1:0]        nz_pad;
   logic [GROUPS-1:0]          grp_nz;
   logic                       grp_hit;
   logic [GROUP_AW-1:0]        grp_sel;
   logic [WB-1:0]              sum_row;
   logic [BAW-1:0]             loc_sel;
   logic [BAW-1:0]             bit_sel;
   logic [GROUP_AW+BAW-1:0]    word_wide;
   logic [WB-1:0]              cur_word;
   logic [WB-1:0]              bit_mask;
   logic [16:0]                page_full;

   assign req_acc = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // page must be non-negative and below the page count
   assign in_range = !req_tdata[15] && ({1'b0, req_tdata} < 17'(PAGES));

   // first level of the search: which summary group holds a nonzero word
   assign nz_pad = SUM_BITS'(nz_ff);
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_nz[g] = |nz_pad[g*WB +: WB];
      end
   end

   always_comb begin
      grp_hit = 1'b0;
      grp_sel = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_nz[g]) begin
            grp_hit = 1'b1;
            grp_sel = GROUP_AW'(g);
         end
      end
   end

   // second level: lowest nonzero word within the chosen group
   assign sum_row = nz_pad[{grp_ff, {BAW{1'b0}}} +: WB];
   always_comb begin
      loc_sel = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (sum_row[b]) begin
            loc_sel = BAW'(b);
         end
      end
   end
   assign word_wide = {grp_ff, loc_sel};

   // third level: lowest set bit of the word read back
   always_comb begin
      bit_sel = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (rd_ff[b]) begin
            bit_sel = BAW'(b);
         end
      end
   end
   assign page_full = 17'({waddr_ff, bit_sel});

   // read-modify-write of one map word; words with a clear summary bit read as zero
   assign cur_word = nz_ff[waddr_ff] ? rd_ff : '0;
   assign bit_mask = WB'(1) << bit_ff;
   assign wr_word  = (kind_ff == fpb_pkg::KIND_MARK_FREE) ? (cur_word | bit_mask)
                                                          : (cur_word & ~bit_mask);
   assign wr_en    = (state_ff == ST_MODIFY);
   assign raddr    = (state_ff == ST_WORD) ? word_wide[WORD_AW-1:0]
                                           : req_tdata[BAW +: WORD_AW];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      waddr_in      = waddr_ff;
      bit_in        = bit_ff;
      grp_in        = grp_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_page_in   = res_page_ff;
      nz_in         = nz_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               kind_in       = req_tuser;
               waddr_in      = req_tdata[BAW +: WORD_AW];
               bit_in        = req_tdata[BAW-1:0];
               res_status_in = fpb_pkg::STATUS_OK;
               res_found_in  = 1'b0;
               res_page_in   = '0;
               case (req_tuser)
                  fpb_pkg::KIND_MARK_FREE, fpb_pkg::KIND_MARK_FULL: begin
                     if (in_range) begin
                        state_in = ST_MODIFY;
                     end else begin
                        res_status_in = fpb_pkg::STATUS_BAD_PAGE;
                        state_in      = ST_DONE;
                     end
                  end
                  fpb_pkg::KIND_FIND: begin
                     grp_in   = grp_sel;
                     state_in = grp_hit ? ST_WORD : ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MODIFY: begin
            nz_in[waddr_ff] = |wr_word;
            state_in        = ST_DONE;
         end
         ST_WORD: begin
            waddr_in = word_wide[WORD_AW-1:0];
            state_in = ST_BIT;
         end
         ST_BIT: begin
            res_found_in = 1'b1;
            res_page_in  = page_full[FPW-1:0];
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_page_in   = res_page_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         nz_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nz_ff        <= nz_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      waddr_ff      <= waddr_in;
      bit_ff        <= bit_in;
      grp_ff        <= grp_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_page_ff   <= res_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_page_ff   <= rsp_page_in;
   end

   // bitmap memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr_ff] <= wr_word;
      end
      rd_ff <= mem[raddr];
   end

   // response word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_page_ff};
   assign rsp_tuser  = {rsp_found_ff, rsp_status_ff};

endmodule
`default_nettype wire
